/* rtl/sstat_pkg.sv */
// Shared types and constants for the sample statistics block.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sstat_pkg;

  localparam int SAMPLE_BITS = 20;
  localparam int MAX_SAMPLES = 256;
  localparam int CNT_W       = 9;
  localparam int SUM_W       = 28;
  localparam int SQ_W        = 48;
  localparam int MSQ_W       = 2 * SAMPLE_BITS;
  localparam int MS_W        = SAMPLE_BITS + SUM_W;
  localparam int PM_W        = CNT_W + MSQ_W;
  localparam int VAR_W       = 50;
  localparam int ROOT_W      = VAR_W / 2;

  localparam logic [SAMPLE_BITS-1:0] MIN_INIT = '1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   present;
    logic                   last;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] minimum;
    logic [SAMPLE_BITS-1:0] maximum;
    logic [SUM_W-1:0]       total;
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] deviation;
    logic [CNT_W-1:0]       entries;
    logic                   empty_set;
    logic                   overflowed;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_var;
    logic mean_cap;
    logic mul_mean;
    logic mul_pres;
    logic var_add;
    logic var_sub;
    logic root_start;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic div_done;
    logic root_done;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/sample_statistics_min_max_mean_std.sv */
// Sample statistics: running min, max, sum, mean and standard deviation.
// Input channel in_valid/in_stall/in_data carries one sample transfer per cycle
// while accumulating; a transfer with last set closes the set.
// Result channel out_valid/out_stall/out_data carries one result per set.
// After a last transfer the input stalls while the finishing arithmetic runs:
// two 50-step serial divides (mean, variance over entries) and a 25-step
// serial square root; a set with no present sample skips these and stalls
// the input only until its result is loaded.
// Samples beyond 256 entries are dropped and reported in overflowed.
// Reset clears all accumulators and the result register valid.
// The result sits in an output register: accumulation of the next set runs
// while it waits; only finishing the next set waits for out_stall to drop.
// Depends on sstat_pkg, sstat_ctrl and sstat_dp.
`timescale 1ns / 1ps
`default_nettype none

module sample_statistics_min_max_mean_std
  import sstat_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sstat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sstat_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

/* rtl/sstat_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sstat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sstat_div
  import sstat_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [VAR_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic      [VAR_W-1:0] quotient,
  output logic                  done
);

  localparam int STEP_W = $clog2(VAR_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [VAR_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dsr_r;

  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              fits;

  assign rem_sh   = {rem_r, quo_r[VAR_W-1]};
  assign fits     = rem_sh >= {1'b0, dsr_r};
  assign rem_diff = fits ? (rem_sh - {1'b0, dsr_r}) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(VAR_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[VAR_W-2:0], fits};
      rem_r <= rem_diff[CNT_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider not busy after start");

endmodule

`default_nettype wire

/* rtl/sstat_sqrt.sv */
// Iterative floor square root, one root bit per cycle.
// Depends on sstat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sstat_sqrt
  import sstat_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [VAR_W-1:0]  radicand,
  output logic      [ROOT_W-1:0] root,
  output logic                   done
);

  localparam int STEP_W = $clog2(ROOT_W);
  localparam int RW     = ROOT_W + 2;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [VAR_W-1:0]  rad_r;
  logic [RW-1:0]     rem_r;
  logic [ROOT_W-1:0] root_r;

  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     trial;
  logic              fits;

  assign rem_sh = {rem_r[RW-3:0], rad_r[VAR_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[VAR_W-3:0], 2'b00};
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

  assign root = root_r;
  assign done = done_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("root done held longer than one cycle");

endmodule

`default_nettype wire

/* rtl/sstat_dp.sv */
// Datapath: running accumulators, variance terms and the result register.
// Depends on sstat_pkg, sstat_div and sstat_sqrt.
`timescale 1ns / 1ps
`default_nettype none

module sstat_dp
  import sstat_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire dp_cmd_t   cmd,
  output dp_stat_t       stat,
  output out_item_t      out_data
);

  logic [SAMPLE_BITS-1:0] min_r;
  logic [SAMPLE_BITS-1:0] max_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SQ_W-1:0]        sumsq_r;
  logic [SQ_W-1:0]        sq_r;
  logic [CNT_W-1:0]       entry_count_r;
  logic [CNT_W-1:0]       present_count_r;
  logic                   dropped_r;

  logic [SAMPLE_BITS-1:0] mean_r;
  logic [MSQ_W-1:0]       msq_r;
  logic [MS_W-1:0]        ms_r;
  logic [PM_W-1:0]        pm_r;
  logic [VAR_W-1:0]       v_r;
  out_item_t              out_r;

  logic                   upd;
  logic                   add_pres;
  logic [MSQ_W-1:0]       smp_ext;
  logic [MSQ_W-1:0]       sq_full;
  logic [VAR_W-1:0]       div_a;
  logic [VAR_W-1:0]       div_q;
  logic [ROOT_W-1:0]      root;
  logic                   empty;

  assign upd      = cmd.accept && (entry_count_r < CNT_W'(MAX_SAMPLES));
  assign add_pres = upd && in_data.present;
  assign smp_ext  = MSQ_W'(in_data.sample);
  assign sq_full  = smp_ext * smp_ext;
  assign empty    = present_count_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      min_r           <= MIN_INIT;
      max_r           <= '0;
      sum_r           <= '0;
      sumsq_r         <= '0;
      sq_r            <= '0;
      entry_count_r   <= '0;
      present_count_r <= '0;
      dropped_r       <= 1'b0;
    end else begin
      sq_r    <= add_pres ? SQ_W'(sq_full) : '0;
      sumsq_r <= sumsq_r + sq_r;
      if (upd) begin
        entry_count_r <= entry_count_r + 1'b1;
      end
      if (add_pres) begin
        present_count_r <= present_count_r + 1'b1;
        sum_r           <= sum_r + SUM_W'(in_data.sample);
        if (in_data.sample < min_r) begin
          min_r <= in_data.sample;
        end
        if (in_data.sample > max_r) begin
          max_r <= in_data.sample;
        end
      end
      if (cmd.accept && !upd) begin
        dropped_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_cap) begin
      mean_r <= div_q[SAMPLE_BITS-1:0];
    end
    if (cmd.mul_mean) begin
      msq_r <= mean_r * mean_r;
      ms_r  <= mean_r * sum_r;
    end
    if (cmd.mul_pres) begin
      pm_r <= present_count_r * msq_r;
    end
    if (cmd.var_add) begin
      v_r <= VAR_W'(sumsq_r) + VAR_W'(pm_r);
    end else if (cmd.var_sub) begin
      v_r <= v_r - VAR_W'({ms_r, 1'b0});
    end
    if (cmd.load) begin
      out_r.minimum    <= min_r;
      out_r.maximum    <= max_r;
      out_r.total      <= sum_r;
      out_r.mean       <= empty ? '0 : mean_r;
      out_r.deviation  <= empty ? '0 : root[SAMPLE_BITS-1:0];
      out_r.entries    <= entry_count_r;
      out_r.empty_set  <= empty;
      out_r.overflowed <= dropped_r;
    end
  end

  assign div_a = cmd.div_var ? v_r : VAR_W'(sum_r);

  sstat_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (entry_count_r),
    .quotient (div_q),
    .done     (stat.div_done)
  );

  sstat_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand (div_q),
    .root     (root),
    .done     (stat.root_done)
  );

  assign stat.empty = empty;
  assign out_data   = out_r;

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_W'(MAX_SAMPLES))
    else $error("entry count beyond limit");

  a_present_le_entries: assert property (@(posedge clk) disable iff (!rst_n)
    present_count_r <= entry_count_r)
    else $error("present count exceeds entry count");

endmodule

`default_nettype wire

/* rtl/sstat_ctrl.sv */
// Controller: sequences accumulation, the finishing arithmetic and result transfer.
// Depends on sstat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sstat_ctrl
  import sstat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_ACC,
    S_SQW,
    S_DIVM,
    S_MUL,
    S_PM,
    S_VADD,
    S_VSUB,
    S_DIVS,
    S_DIVV,
    S_ROOT,
    S_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_ACC: begin
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_SQW;
        end
      end
      S_SQW: begin
        if (stat.empty) begin
          state_nxt = S_LOAD;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVM;
        end
      end
      S_DIVM: begin
        if (stat.div_done) begin
          cmd.mean_cap = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_mean = 1'b1;
        state_nxt    = S_PM;
      end
      S_PM: begin
        cmd.mul_pres = 1'b1;
        state_nxt    = S_VADD;
      end
      S_VADD: begin
        cmd.var_add = 1'b1;
        state_nxt   = S_VSUB;
      end
      S_VSUB: begin
        cmd.var_sub = 1'b1;
        state_nxt   = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        cmd.div_var   = 1'b1;
        state_nxt     = S_DIVV;
      end
      S_DIVV: begin
        cmd.div_var = 1'b1;
        if (stat.div_done) begin
          cmd.root_start = 1'b1;
          state_nxt      = S_ROOT;
        end
      end
      S_ROOT: begin
        if (stat.root_done) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_ACC;
  assign out_valid = out_valid_r;

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input not held off after last transfer");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("result loaded without valid");

endmodule

`default_nettype wire

/* bench/sstat_result_checker.sv */
// Result checker for the sample statistics block: watches both channels,
// predicts each set's statistics and compares every result transfer.
// Depends on sstat_pkg for the transfer types and widths.
`timescale 1ns / 1ps

module sstat_result_checker
  import sstat_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        pending,
  output int        fail_count
);

  logic [SAMPLE_BITS-1:0] acc_min;
  logic [SAMPLE_BITS-1:0] acc_max;
  logic [SUM_W-1:0]       acc_sum;
  logic [SQ_W-1:0]        acc_sumsq;
  logic [CNT_W-1:0]       acc_entries;
  logic [CNT_W-1:0]       acc_present;
  logic                   acc_dropped;
  out_item_t              stats_due[$];
  int                     fails = 0;

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  function automatic void clear_set();
    acc_min     = MIN_INIT;
    acc_max     = '0;
    acc_sum     = '0;
    acc_sumsq   = '0;
    acc_entries = '0;
    acc_present = '0;
    acc_dropped = 1'b0;
  endfunction

  function automatic logic [31:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[31:0];
  endfunction

  function automatic out_item_t close_set();
    out_item_t   r;
    logic [63:0] n;
    logic [63:0] p;
    logic [63:0] avg;
    logic [63:0] spread;
    logic [31:0] root;
    r            = '0;
    r.minimum    = acc_min;
    r.maximum    = acc_max;
    r.total      = acc_sum;
    r.entries    = acc_entries;
    r.empty_set  = (acc_present == 0);
    r.overflowed = acc_dropped;
    if (acc_entries != 0 && acc_present != 0) begin
      n      = 64'(acc_entries);
      p      = 64'(acc_present);
      avg    = 64'(acc_sum) / n;
      spread = 64'(acc_sumsq) + p * avg * avg - 64'd2 * avg * 64'(acc_sum);
      root   = floor_root(spread / n);
      r.mean      = avg[SAMPLE_BITS-1:0];
      r.deviation = root[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  function automatic void absorb_sample(input in_item_t it);
    if (acc_entries < MAX_SAMPLES) begin
      acc_entries = acc_entries + 1'b1;
      if (it.present) begin
        acc_present = acc_present + 1'b1;
        if (it.sample < acc_min) acc_min = it.sample;
        if (it.sample > acc_max) acc_max = it.sample;
        acc_sum   = acc_sum + SUM_W'(it.sample);
        acc_sumsq = acc_sumsq + SQ_W'(it.sample) * SQ_W'(it.sample);
      end
    end else begin
      acc_dropped = 1'b1;
    end
    if (it.last) begin
      stats_due.push_back(close_set());
      clear_set();
    end
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      clear_set();
      stats_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (stats_due.size() == 0) begin
          $error("result transfer with no statistics expected");
          fails++;
        end else begin
          want = stats_due.pop_front();
          check_field("minimum", 64'(want.minimum), 64'(out_data.minimum));
          check_field("maximum", 64'(want.maximum), 64'(out_data.maximum));
          check_field("total", 64'(want.total), 64'(out_data.total));
          check_field("mean", 64'(want.mean), 64'(out_data.mean));
          check_field("deviation", 64'(want.deviation), 64'(out_data.deviation));
          check_field("entries", 64'(want.entries), 64'(out_data.entries));
          check_field("empty_set", 64'(want.empty_set), 64'(out_data.empty_set));
          check_field("overflowed", 64'(want.overflowed), 64'(out_data.overflowed));
        end
      end
      if (in_valid && !in_stall) absorb_sample(in_data);
    end
    pending    <= stats_due.size();
    fail_count <= fails;
  end

endmodule

/* bench/sample_statistics_min_max_mean_std_tb.sv */
// Testbench top for the sample statistics block: clock, reset, sample sets
// with bursty input and random output stall, and the final verdict.
// Depends on sstat_pkg, the block and sstat_result_checker.
`timescale 1ns / 1ps

module sample_statistics_min_max_mean_std_tb;
  import sstat_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 270;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [SAMPLE_BITS-1:0] TOP_SAMPLE = '1;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;
  int        pending;
  int        fail_count;
  int        cycles     = 0;
  int        burst_left = 0;
  int        items_sent = 0;

  always #5 clk = ~clk;

  sample_statistics_min_max_mean_std i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sstat_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  function automatic in_item_t make_item(input logic [SAMPLE_BITS-1:0] s, input logic p,
                                         input logic l);
    in_item_t it;
    it.sample  = s;
    it.present = p;
    it.last    = l;
    return it;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return TOP_SAMPLE;
      2: return TOP_SAMPLE - SAMPLE_BITS'($urandom_range(0, 255));
      3: return SAMPLE_BITS'($urandom_range(0, 255));
      4: return SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_random_set(input int len);
    int                     mode;
    logic [SAMPLE_BITS-1:0] base;
    logic [SAMPLE_BITS-1:0] val;
    logic                   pres;
    mode = $urandom_range(0, 9);
    base = rand_sample();
    for (int k = 0; k < len; k++) begin
      case (mode)
        0:       pres = 1'b0;
        1, 2, 3: pres = 1'b1;
        default: pres = ($urandom_range(0, 3) != 0);
      endcase
      val = (mode == 3) ? base + SAMPLE_BITS'($urandom_range(0, 15)) : rand_sample();
      send_item(make_item(val, pres, k == len - 1));
    end
  endtask

  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int start;
    int sets;
    int len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_item(make_item('0, 1'b1, 1'b1));
    send_item(make_item(TOP_SAMPLE, 1'b1, 1'b1));
    send_item(make_item(TOP_SAMPLE, 1'b0, 1'b1));
    send_item(make_item('0, 1'b1, 1'b0));
    send_item(make_item(TOP_SAMPLE, 1'b1, 1'b0));
    send_item(make_item(TOP_SAMPLE, 1'b0, 1'b0));
    send_item(make_item('0, 1'b0, 1'b1));
    send_item(make_item(TOP_SAMPLE, 1'b1, 1'b0));
    send_item(make_item(TOP_SAMPLE, 1'b1, 1'b1));
    send_item(make_item('0, 1'b0, 1'b0));
    send_item(make_item(20'hAAAAA, 1'b0, 1'b0));
    send_item(make_item(20'h55555, 1'b0, 1'b1));
    send_item(make_item(20'd1, 1'b1, 1'b0));
    send_item(make_item(20'd2, 1'b1, 1'b0));
    send_item(make_item(20'd3, 1'b1, 1'b0));
    send_item(make_item(20'd1000000, 1'b1, 1'b1));
    send_item(make_item(20'h55555, 1'b1, 1'b0));
    send_item(make_item(20'hAAAAA, 1'b1, 1'b1));
    wait_drained();

    for (int k = 0; k < MAX_SAMPLES + 4; k++) begin
      send_item(make_item(TOP_SAMPLE, 1'b1, k == MAX_SAMPLES + 3));
    end

    start = items_sent;
    sets  = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_random_set(len);
      sets++;
      if (sets == 15) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sstat_pkg.sv
rtl/sstat_div.sv
rtl/sstat_sqrt.sv
rtl/sstat_dp.sv
rtl/sstat_ctrl.sv
rtl/sample_statistics_min_max_mean_std.sv
bench/sstat_result_checker.sv
bench/sample_statistics_min_max_mean_std_tb.sv
